/* hw/rtl/box_filter_3x3_core_defines.svh */
// Assertion macros for the 3x3 box filter core and its port checker.
// No dependencies; included by the checker file.
`ifndef BOX_FILTER_3X3_CORE_DEFINES_SVH
`define BOX_FILTER_3X3_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bf3 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bf3 check failed");

`endif

/* hw/rtl/bf3_pkg.sv */
// Shared constants and types for the 3x3 box filter core.
// No dependencies; used by box_filter_3x3_core and bf3_checker.
`default_nettype none

package bf3_pkg;

    // default size limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // field widths
    localparam int PIXEL_W        = 8;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam int MEAN_W         = 12;
    localparam int ROW_W          = 12;
    localparam int COL_W          = 10;
    localparam int SUM_W          = 12;   // 9 * 255 = 2295

    // stream and config port widths
    localparam int S_TDATA_W  = ((PIXEL_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = MEAN_W + ROW_W + COL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_FIELD_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // register reset values
    localparam logic [WIDTH_FIELD_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_FIELD_W-1:0] HEIGHT_RESET = 13'd480;

    // floor(x * 16 / 9) = (x * 58255) >> 15, exact for x < 4681
    localparam int MUL_W      = 16;
    localparam int PROD_W     = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV9_MUL = 16'd58255;
    localparam int DIV9_SHIFT = 15;
    localparam logic [MEAN_W-1:0] MEAN_MAX = 12'd4080;

    // result kinds, one bit each in the pending mask, in emission order
    localparam int EMIT_UL   = 0;   // (r-1, c-1)
    localparam int EMIT_UP   = 1;   // (r-1, c), right edge
    localparam int EMIT_LEFT = 2;   // (r, c-1), last row
    localparam int EMIT_SELF = 3;   // (r, c), last pixel of image
    localparam int EMIT_N    = 4;

    // position flags of an input pixel
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic r_last;
        logic c_ge1;
        logic c_ge2;
        logic c_last;
    } edge_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/box_filter_3x3_core.sv */
// 3x3 zero-padded box (mean) filter over a raster pixel stream.
// Depends on bf3_pkg. Two line-buffer RAMs plus a 3x3 window register.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+--------------------------------------
//  s_       | in  | s_tvalid / s_tready    | s_tdata: pixel_value
//  m_       | out | m_tvalid / m_tready    | m_tdata: mean_value,out_row,out_col
//           |     |                        | m_tlast: last_of_image
//  cfg_     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel per clock while m_ is not stalled. A pixel that yields k results
// (k = 0..4) holds the input until the window stage, which hands out one
// result per cycle while m_ is not stalled, has issued the last of them.
// aresetn is synchronous; no RAM clearing pass, line buffers start undefined.
// Stalls on m_ back up through the pipeline to s_tready; cfg_ready is always high.
`default_nettype none

module box_filter_3x3_core #(
    parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bf3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bf3_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] pixel_value
    // filtered output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bf3_pkg::M_TDATA_W-1:0]    m_tdata,   // [11:0] mean_value,
                                                        // [23:12] out_row,
                                                        // [33:24] out_col, rest zero
    output logic                             m_tlast,   // last_of_image
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW        = bf3_pkg::PIXEL_W;
    localparam int SW        = bf3_pkg::SUM_W;
    localparam int MW        = bf3_pkg::MEAN_W;
    localparam int ROW_OUT_W = bf3_pkg::ROW_W;
    localparam int COL_OUT_W = bf3_pkg::COL_W;
    localparam int PRW       = bf3_pkg::PROD_W;
    localparam int NK        = bf3_pkg::EMIT_N;
    localparam int PAD_W     = bf3_pkg::M_TDATA_W - bf3_pkg::M_FIELDS_W;

    // Sizes are clamped into 1..MAX and kept as "last index".
    function automatic logic [CW-1:0] width_last(
        input logic [bf3_pkg::WIDTH_FIELD_W-1:0] v);
        int t;
        t = int'(v);
        if (t == 0) begin
            t = 1;
        end else if (t > MAX_WIDTH) begin
            t = MAX_WIDTH;
        end
        return CW'(t - 1);
    endfunction

    function automatic logic [RW-1:0] height_last(
        input logic [bf3_pkg::HEIGHT_FIELD_W-1:0] v);
        int t;
        t = int'(v);
        if (t == 0) begin
            t = 1;
        end else if (t > MAX_HEIGHT) begin
            t = MAX_HEIGHT;
        end
        return RW'(t - 1);
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic          cfg_fire;
    logic          cfg_clr;
    logic [CW-1:0] wlast_reg;
    logic [RW-1:0] hlast_reg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    // a write to either register restarts the image
    assign cfg_clr   = cfg_fire && (cfg_index == bf3_pkg::REG_IMAGE_WIDTH ||
                                    cfg_index == bf3_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg <= width_last(bf3_pkg::WIDTH_RESET);
            hlast_reg <= height_last(bf3_pkg::HEIGHT_RESET);
        end else if (cfg_fire) begin
            if (cfg_index == bf3_pkg::REG_IMAGE_WIDTH) begin
                wlast_reg <= width_last(cfg_data[bf3_pkg::WIDTH_FIELD_W-1:0]);
            end
            if (cfg_index == bf3_pkg::REG_IMAGE_HEIGHT) begin
                hlast_reg <= height_last(cfg_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, position counters, line-buffer read issue
    // ------------------------------------------------------------------
    logic                 s_fire;
    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    bf3_pkg::edge_flags_t s0_flags;

    // stage 1 / 2 handshake (defined below)
    logic s1_valid_reg, s1_valid_next;
    logic s1_adv;
    logic s2_free;

    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        s0_flags.r_ge1  = (row_reg != '0);
        s0_flags.r_ge2  = (int'(row_reg) >= 2);
        s0_flags.r_last = (row_reg == hlast_reg);
        s0_flags.c_ge1  = (col_reg != '0);
        s0_flags.c_ge2  = (int'(col_reg) >= 2);
        s0_flags.c_last = (col_reg == wlast_reg);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_clr) begin
            col_next = '0;
            row_next = '0;
        end else if (s_fire) begin
            if (s0_flags.c_last) begin
                col_next = '0;
                row_next = s0_flags.r_last ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line-buffer data back, write-back, window shift
    // ------------------------------------------------------------------
    logic [PW-1:0]        s1_px_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [RW-1:0]        s1_row_reg;
    bf3_pkg::edge_flags_t s1_flags_reg;
    logic [PW-1:0]        up_rd_reg, mid_rd_reg;
    logic                 fwd_reg;
    logic [PW-1:0]        fwd_up_reg, fwd_mid_reg;
    logic [PW-1:0]        up_eff, mid_eff;
    logic                 fwd_hit;

    logic [PW-1:0] lb_upper_mem  [MAX_WIDTH];
    logic [PW-1:0] lb_middle_mem [MAX_WIDTH];

    // Same column read while stage 1 writes it (only at width 1): the RAM
    // returns old data, so the written values are forwarded.
    assign fwd_hit = s_fire && s1_adv && (col_reg == s1_col_reg);
    assign up_eff  = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_eff = fwd_reg ? fwd_mid_reg : mid_rd_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            lb_upper_mem[s1_col_reg] <= mid_eff;
        end
        if (s_fire) begin
            up_rd_reg <= lb_upper_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            lb_middle_mem[s1_col_reg] <= s1_px_reg;
        end
        if (s_fire) begin
            mid_rd_reg <= lb_middle_mem[col_reg];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (s_fire) begin
                fwd_reg <= fwd_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_px_reg    <= s_tdata[PW-1:0];
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_flags_reg <= s0_flags;
            fwd_up_reg   <= mid_eff;
            fwd_mid_reg  <= s1_px_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: window holds; while not stalled, hands out pending results one per cycle
    // ------------------------------------------------------------------
    logic [PW-1:0]        win_reg [3][3];   // [row r-2..r][col c-2..c]
    logic [CW-1:0]        s2_col_reg;
    logic [RW-1:0]        s2_row_reg;
    bf3_pkg::edge_flags_t s2_flags_reg;
    logic [NK-1:0]        pend_reg, pend_next;
    logic [NK-1:0]        pick;
    logic [NK-1:0]        s1_mask;
    logic                 issue;
    logic                 dr, dc;
    logic [2:0]           row_ok, col_ok;
    logic [SW-1:0]        win_sum;
    logic [RW-1:0]        o_row;
    logic [CW-1:0]        o_col;

    logic s3_valid_reg;
    logic s3_en, s4_en;
    logic m_tvalid_reg;

    assign s4_en = !m_tvalid_reg || m_tready;
    assign s3_en = !s3_valid_reg || s4_en;

    assign pick    = pend_reg & (~pend_reg + NK'(1));
    assign issue   = (pend_reg != '0) && s3_en;
    assign s2_free = (pend_reg == '0) || ((pick == pend_reg) && s3_en);
    assign s1_adv  = s1_valid_reg && s2_free;

    always_comb begin
        s1_mask[bf3_pkg::EMIT_UL]   = s1_flags_reg.r_ge1  && s1_flags_reg.c_ge1;
        s1_mask[bf3_pkg::EMIT_UP]   = s1_flags_reg.r_ge1  && s1_flags_reg.c_last;
        s1_mask[bf3_pkg::EMIT_LEFT] = s1_flags_reg.r_last && s1_flags_reg.c_ge1;
        s1_mask[bf3_pkg::EMIT_SELF] = s1_flags_reg.r_last && s1_flags_reg.c_last;
    end

    always_comb begin
        pend_next = pend_reg;
        if (s1_adv) begin
            pend_next = s1_mask;
        end else if (issue) begin
            pend_next = pend_reg & ~pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= up_eff;
            win_reg[1][2] <= mid_eff;
            win_reg[2][2] <= s1_px_reg;
            s2_col_reg    <= s1_col_reg;
            s2_row_reg    <= s1_row_reg;
            s2_flags_reg  <= s1_flags_reg;
        end
    end

    // Result sits one row up (dr) and/or one column left (dc) of the window's
    // newest pixel. Neighbors past the right/bottom edge are never in the
    // window; top/left padding comes from the position flags.
    assign dr = pick[bf3_pkg::EMIT_UL] || pick[bf3_pkg::EMIT_UP];
    assign dc = pick[bf3_pkg::EMIT_UL] || pick[bf3_pkg::EMIT_LEFT];

    always_comb begin
        row_ok[2] = 1'b1;
        row_ok[1] = s2_flags_reg.r_ge1;
        row_ok[0] = s2_flags_reg.r_ge2 && dr;
        col_ok[2] = 1'b1;
        col_ok[1] = s2_flags_reg.c_ge1;
        col_ok[0] = s2_flags_reg.c_ge2 && dc;
    end

    always_comb begin
        win_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_ok[i] && col_ok[j]) begin
                    win_sum = win_sum + SW'(win_reg[i][j]);
                end
            end
        end
    end

    assign o_row = s2_row_reg - RW'(dr);
    assign o_col = s2_col_reg - CW'(dc);

    // ------------------------------------------------------------------
    // Stage 3: registered sum; stage 4: scale by 16/9 into output register
    // ------------------------------------------------------------------
    logic [SW-1:0]        s3_sum_reg;
    logic [ROW_OUT_W-1:0] s3_row_reg;
    logic [COL_OUT_W-1:0] s3_col_reg;
    logic                 s3_last_reg;
    logic [PRW-1:0]       prod;
    logic [MW-1:0]        mean_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic                 out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s3_en) begin
                s3_valid_reg <= issue;
            end
            if (s4_en) begin
                m_tvalid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_en && issue) begin
            s3_sum_reg  <= win_sum;
            s3_row_reg  <= ROW_OUT_W'(o_row);
            s3_col_reg  <= COL_OUT_W'(o_col);
            s3_last_reg <= pick[bf3_pkg::EMIT_SELF];
        end
    end

    // floor(sum * 16 / 9) by reciprocal multiply
    assign prod = PRW'(s3_sum_reg) * PRW'(bf3_pkg::DIV9_MUL);

    always_ff @(posedge aclk) begin
        if (s4_en && s3_valid_reg) begin
            mean_reg     <= prod[bf3_pkg::DIV9_SHIFT +: MW];
            out_row_reg  <= s3_row_reg;
            out_col_reg  <= s3_col_reg;
            out_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_col_reg, out_row_reg, mean_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/bf3_checker.sv */
// Port-level checker for box_filter_3x3_core, bound to the top level.
// Depends on bf3_pkg and box_filter_3x3_core_defines.svh.
`default_nettype none
`include "box_filter_3x3_core_defines.svh"

module bf3_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bf3_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // a stalled result keeps its payload
    `BF3_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // out of reset the pipeline is empty and takes pixels
    `BF3_ASSERT_NOW(a_reset_empty, aclk, aresetn, $past(!aresetn), !m_tvalid && s_tready)

    // divide-by-nine never exceeds the full-scale mean
    `BF3_ASSERT_NOW(a_mean_range, aclk, aresetn, m_tvalid, m_tdata[11:0] <= bf3_pkg::MEAN_MAX)

    // register writes never wait
    `BF3_ASSERT_NOW(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind box_filter_3x3_core bf3_checker u_bf3_checker (.*);

`default_nettype wire

/* dv/box_filter_3x3_core_tb.sv */
// Self-checking testbench for box_filter_3x3_core: predicts every filtered pixel
// and compares each item leaving m_ against it. Depends on bf3_pkg and the core.
`timescale 1ns / 1ps

package bf3_tb_pkg;

    import bf3_pkg::*;

    // index with no register behind it: the write is dropped, counters keep running
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } filt_px_t;

    class mean_scoreboard;
        logic [PIXEL_W-1:0]        upper_line [MAX_WIDTH_DEF];
        logic [PIXEL_W-1:0]        middle_line [MAX_WIDTH_DEF];
        logic [PIXEL_W-1:0]        win [9];
        int                        row_pos;
        int                        col_pos;
        logic [WIDTH_FIELD_W-1:0]  width_reg;
        logic [HEIGHT_FIELD_W-1:0] height_reg;
        filt_px_t                  expected_q [$];
        int                        errors;

        function new();
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                middle_line[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            row_pos = 0;
            col_pos = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
            return int'(height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH: begin
                    width_reg = val[WIDTH_FIELD_W-1:0];
                    row_pos = 0;
                    col_pos = 0;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = val;
                    row_pos = 0;
                    col_pos = 0;
                end
                default: ;
            endcase
        endfunction

        // Sum of the neighbors of (orow, ocol) that lie in the image; the window
        // covers input rows r-2..r and columns c-2..c.
        function int unsigned neighbor_sum(int orow, int ocol, int r, int c, int w, int h);
            int unsigned s;
            int y, x, wr, wc;
            s = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    y = orow + dr;
                    x = ocol + dc;
                    wr = y - r + 2;
                    wc = x - c + 2;
                    if (y >= 0 && y < h && x >= 0 && x < w &&
                        wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2)
                        s += win[wr * 3 + wc];
                end
            end
            return s;
        endfunction

        function void push_mean(int orow, int ocol, int r, int c, int w, int h,
                                logic last);
            filt_px_t px;
            int unsigned s;
            s = neighbor_sum(orow, ocol, r, c, w, h);
            px.mean = MEAN_W'((s * 16) / 9);
            px.row = ROW_W'(orow);
            px.col = COL_W'(ocol);
            px.last = last;
            expected_q.push_back(px);
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] pix);
            int w, h, r, c;
            logic [PIXEL_W-1:0] up, mid;
            w = eff_width();
            h = eff_height();
            r = row_pos;
            c = col_pos;
            if (r >= h) r = h - 1;
            if (c >= w) c = w - 1;
            up = upper_line[c];
            mid = middle_line[c];
            upper_line[c] = mid;
            middle_line[c] = pix;
            for (int k = 0; k < 3; k++) begin
                win[k * 3] = win[k * 3 + 1];
                win[k * 3 + 1] = win[k * 3 + 2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = pix;
            if (r >= 1 && c >= 1) push_mean(r - 1, c - 1, r, c, w, h, 1'b0);
            if (r >= 1 && c == w - 1) push_mean(r - 1, c, r, c, w, h, 1'b0);
            if (r == h - 1 && c >= 1) push_mean(r, c - 1, r, c, w, h, 1'b0);
            if (r == h - 1 && c == w - 1) push_mean(r, c, r, c, w, h, 1'b1);
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(filt_px_t got, logic [M_TDATA_W-M_FIELDS_W-1:0] pad);
            filt_px_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected item row %0d col %0d mean %0d",
                                 got.row, got.col, got.mean));
                return;
            end
            want = expected_q.pop_front();
            if (got.mean !== want.mean)
                report($sformatf("mean at (%0d,%0d): got %0d, expected %0d",
                                 want.row, want.col, got.mean, want.mean));
            if (got.row !== want.row)
                report($sformatf("row: got %0d, expected %0d", got.row, want.row));
            if (got.col !== want.col)
                report($sformatf("col: got %0d, expected %0d", got.col, want.col));
            if (got.last !== want.last)
                report($sformatf("tlast at (%0d,%0d): got %b, expected %b",
                                 want.row, want.col, got.last, want.last));
            if (pad !== '0)
                report($sformatf("tdata pad bits not zero: %h", pad));
        endtask
    endclass

endpackage

module box_filter_3x3_core_tb;

    import bf3_pkg::*;
    import bf3_tb_pkg::*;

    // settle time after the last expected item
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mean_scoreboard sb;
    int             cycle_count = 0;
    int             tx_idle_pct = 0;    // chance per cycle that the sender idles
    int             rx_stall_pct = 0;   // chance per cycle that m_tready drops
    logic           rx_hold = 1'b0;     // long back-pressure window

    box_filter_3x3_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls per cycle, forced low during a hold window.
    always @(posedge aclk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Handshakes are sampled at the falling edge: everything is driven at the
    // rising edge, so what is high here is what the next rising edge accepts.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_result({m_tdata[MEAN_W-1:0],
                             m_tdata[MEAN_W +: ROW_W],
                             m_tdata[MEAN_W+ROW_W +: COL_W],
                             m_tlast},
                            m_tdata[M_TDATA_W-1:M_FIELDS_W]);
    end

    // Keeps m_tready low through a hold window whose length n is counted here while the sender runs on.
    task automatic hold_receiver(int n);
        rx_hold <= 1'b1;
        repeat (n) @(posedge aclk);
        rx_hold <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom_range(255));
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(9))
            0: return 0;                    // acts as 1
            1: return 1;
            9: return $urandom_range(16, 9);
            default: return $urandom_range(7, 2);
        endcase
    endfunction

    function automatic int pick_height();
        case ($urandom_range(9))
            0: return 0;                    // acts as 1
            1: return 1;
            9: return $urandom_range(8, 6);
            default: return $urandom_range(5, 2);
        endcase
    endfunction

    // One pixel item; random idle cycles first. Returns at the accepting edge
    // with s_tvalid still high so back-to-back items go out without a gap.
    task automatic send_pixel(logic [PIXEL_W-1:0] pix);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(pix);
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        sb.note_pixel(pix);
    endtask

    task automatic send_pixels(int n);
        repeat (n) send_pixel(pick_pixel());
    endtask

    // Stop the input and wait until every predicted item has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes only go in while the core is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_size(int w, int h);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Mostly whole images of random small size and content; some runs stop
    // part way or spill into the next image, and some carry a dead write.
    task automatic run_mix(int items, int tx_pct, int rx_pct);
        int sent, w, h, area, n, half;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < items) begin
            w = pick_width();
            h = pick_height();
            set_size(w, h);
            area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            if ($urandom_range(4) == 0)
                n = $urandom_range(2 * area, 1);
            else
                n = area * $urandom_range(2, 1);
            half = n / 2;
            send_pixels(half);
            // a write to an unmapped index must not restart the image
            if ($urandom_range(5) == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(8191)));
            send_pixels(n - half);
            sent += n;
        end
    endtask

    logic [PIXEL_W-1:0] corner_mix [9] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F,
                                           8'hFE, 8'h55, 8'hAA, 8'h00};

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset sizes (640 x 480): a few first-row pixels, which yield no
        // results; the next size write restarts the image.
        send_pixels(6);

        // Directed: full-scale 3x3 image gives the top mean at its center,
        // then edge values, 1x1 images from zero sizes, a single column, and
        // a dead write in the middle of a 2x2 image.
        set_size(3, 3);
        repeat (9) send_pixel('1);
        foreach (corner_mix[i]) send_pixel(corner_mix[i]);
        set_size(0, 0);
        send_pixel('1);
        send_pixel(8'h3C);
        set_size(1, 3);
        send_pixels(3);
        set_size(2, 2);
        send_pixels(2);
        write_reg(REG_SPARE, '1);
        send_pixels(2);

        // Random traffic under each idling profile.
        run_mix(30, 0, 0);
        run_mix(30, 80, 0);
        run_mix(30, 0, 80);
        run_mix(30, 35, 35);

        // Back-pressure: hold the output long enough that the core fills and
        // stalls its input, then pause mid-image until everything is out.
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_size(8, 4);
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        send_pixels(32);
        set_size(5, 4);
        send_pixels(10);
        wait_idle();
        send_pixels(10);

        // Size extremes: width above range (clamped to max), height above
        // range (clamped).
        tx_idle_pct = 10;
        rx_stall_pct = 10;
        set_size(8191, 1);
        send_pixels(20);
        set_size(1, 8191);
        send_pixels(16);

        run_mix(30, 35, 35);

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bf3_pkg.sv
hw/rtl/box_filter_3x3_core.sv
hw/rtl/bf3_checker.sv
dv/box_filter_3x3_core_tb.sv
